// ----- sv/smsp_pkg.sv -----
package smsp_pkg;

    // Most hex characters one input word can produce: header, digit pair, trailer.
    localparam int unsigned MAX_RESULTS = 20;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes.
    localparam logic CFG_ADDRESS_DIGITS = 1'b0;
    localparam logic CFG_MESSAGE_LENGTH = 1'b1;

    // Input kinds.
    localparam logic KIND_DIGIT   = 1'b0;
    localparam logic KIND_MESSAGE = 1'b1;

    // Pad character for an odd final digit.
    localparam logic [7:0] ASCII_F = 8'h46;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_in;
        logic       last_of_kind;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       frame_end;
    } out_word_t;

    // Characters produced by one input word, first character in slot 0.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [CNT_W-1:0]            count;
        logic                        frame_end;
    } job_t;

    // Uppercase hex digit in ASCII.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

// ----- sv/smsp_encode.sv -----
module smsp_encode
    import smsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  in_word_t   word,
    input  logic [4:0] address_digits,
    input  logic [7:0] message_length,
    output job_t       job
);

    logic [13:0] acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [7:0]  held_reg, held_next;
    logic        odd_reg, odd_next;
    logic        hdr_reg, hdr_next;
    logic        done_reg, done_next;

    // Frame state advances only when the word is handed to the serializer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            pend_reg <= '0;
            held_reg <= '0;
            odd_reg  <= 1'b0;
            hdr_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (fire) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            held_reg <= held_next;
            odd_reg  <= odd_next;
            hdr_reg  <= hdr_next;
            done_reg <= done_next;
        end
    end

    // Build the character list for one word and the next frame state.
    always_comb begin
        logic [CNT_W-1:0] base;
        logic [13:0]      merged;
        logic [13:0]      shifted;
        logic             clear;

        job       = '0;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        hdr_next  = hdr_reg;
        done_next = done_reg;
        base      = '0;
        merged    = '0;
        shifted   = '0;
        clear     = 1'b0;

        if (word.kind == KIND_DIGIT) begin
            if (!done_reg) begin
                // Header goes out ahead of the first digit.
                if (!hdr_reg) begin
                    job.chars[0] = hex_char(4'h0);
                    job.chars[1] = hex_char(4'h0);
                    job.chars[2] = hex_char(4'h1);
                    job.chars[3] = hex_char(4'h1);
                    job.chars[4] = hex_char(4'h0);
                    job.chars[5] = hex_char(4'h0);
                    job.chars[6] = hex_char({3'b000, address_digits[4]});
                    job.chars[7] = hex_char(address_digits[3:0]);
                    job.chars[8] = hex_char(4'h9);
                    job.chars[9] = hex_char(4'h1);
                    base         = CNT_W'(10);
                    hdr_next     = 1'b1;
                end
                // Digits go out as swapped pairs; a lone final digit is padded.
                if (odd_reg) begin
                    job.chars[base]              = word.char_in;
                    job.chars[base + CNT_W'(1)]  = held_reg;
                    odd_next                     = 1'b0;
                    held_next                    = '0;
                    base                         = base + CNT_W'(2);
                end else if (word.last_of_kind) begin
                    job.chars[base]              = ASCII_F;
                    job.chars[base + CNT_W'(1)]  = word.char_in;
                    base                         = base + CNT_W'(2);
                end else begin
                    held_next = word.char_in;
                    odd_next  = 1'b1;
                end
                // Trailer with the user data length follows the last digit.
                if (word.last_of_kind) begin
                    job.chars[base]             = hex_char(4'h0);
                    job.chars[base + CNT_W'(1)] = hex_char(4'h0);
                    job.chars[base + CNT_W'(2)] = hex_char(4'h0);
                    job.chars[base + CNT_W'(3)] = hex_char(4'h0);
                    job.chars[base + CNT_W'(4)] = hex_char(4'h0);
                    job.chars[base + CNT_W'(5)] = hex_char(4'hB);
                    job.chars[base + CNT_W'(6)] = hex_char(message_length[7:4]);
                    job.chars[base + CNT_W'(7)] = hex_char(message_length[3:0]);
                    base                        = base + CNT_W'(8);
                    done_next                   = 1'b1;
                    if (message_length == 8'd0) begin
                        job.frame_end = 1'b1;
                        clear         = 1'b1;
                    end
                end
                job.count = base;
            end
        end else begin
            if (done_reg) begin
                // Septet packing: a full octet leaves whenever eight bits are held.
                merged = acc_reg | (14'({word.char_in[6:0]}) << pend_reg);
                if (pend_reg != 3'd0) begin
                    job.chars[0] = hex_char(merged[7:4]);
                    job.chars[1] = hex_char(merged[3:0]);
                    shifted      = {8'h00, merged[13:8]};
                    pend_next    = pend_reg - 3'd1;
                    base         = CNT_W'(2);
                end else begin
                    shifted   = merged;
                    pend_next = 3'd7;
                end
                acc_next = shifted;
                // The last character flushes the partial octet and ends the frame.
                if (word.last_of_kind) begin
                    if (pend_next != 3'd0) begin
                        job.chars[base]             = hex_char(shifted[7:4]);
                        job.chars[base + CNT_W'(1)] = hex_char(shifted[3:0]);
                        base                        = base + CNT_W'(2);
                    end
                    job.frame_end = 1'b1;
                    clear         = 1'b1;
                end
                job.count = base;
            end
        end

        if (clear) begin
            acc_next  = '0;
            pend_next = '0;
            held_next = '0;
            odd_next  = 1'b0;
            hdr_next  = 1'b0;
            done_next = 1'b0;
        end
    end

endmodule

// ----- sv/smsp_serial.sv -----
module smsp_serial
    import smsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  job_t      job,
    output logic      free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic [MAX_RESULTS-1:0][7:0] chars_reg;
    logic [CNT_W-1:0]            remain_reg;
    logic                        fe_reg;
    logic                        take;

    assign take    = m_valid && m_ready;
    assign m_valid = remain_reg != '0;

    // A new list may load when nothing is left or the last word is leaving now.
    assign free = (remain_reg == '0) || ((remain_reg == CNT_W'(1)) && m_ready);

    assign m_data.out_char  = chars_reg[0];
    assign m_data.run_last  = remain_reg == CNT_W'(1);
    assign m_data.frame_end = (remain_reg == CNT_W'(1)) && fe_reg;

    // Count of words still to send.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else if (load) begin
            remain_reg <= job.count;
        end else if (take) begin
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    // Character shift line; slot 0 is always the word on the output.
    always_ff @(posedge aclk) begin
        if (load) begin
            chars_reg <= job.chars;
            fe_reg    <= job.frame_end;
        end else if (take) begin
            chars_reg <= {8'h00, chars_reg[MAX_RESULTS-1:1]};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        remain_reg <= CNT_W'(MAX_RESULTS))
        else $error("serializer count above list size");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(remain_reg) && $stable(chars_reg[0])))
        else $error("serializer moved while stalled");

    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("serializer loaded while busy");

    a_drain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !load) |=> (remain_reg == $past(remain_reg) - CNT_W'(1)))
        else $error("serializer count did not step on a taken word");

endmodule

// ----- sv/sms_submit_pdu_hex_encoder.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_data  : kind, char_in, last_of_kind
// m_       out        m_valid/m_ready    m_data  : out_char, run_last, frame_end
// cfg_     in         cfg_wr_en          cfg_addr, cfg_wr_data (no ready)
//
// An input word is held in the input register and is then encoded in one pass; it
// yields 0 to 20 hex words, sent one per cycle from a shift line while m_ready is
// high.
// The next item is taken while the last word of the previous one leaves.
// aresetn is synchronous and active low; config registers keep values across frames.
// A stall on m_ready holds the output word and backs up into s_ready.
module sms_submit_pdu_hex_encoder
    import smsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wr_data
);

    logic       in_valid_reg;
    in_word_t   in_reg;
    logic [4:0] addr_digits_reg;
    logic [7:0] msg_len_reg;
    logic       ser_free;
    logic       load;
    job_t       job;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_digits_reg <= 5'd1;
            msg_len_reg     <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ADDRESS_DIGITS: addr_digits_reg <= cfg_wr_data[4:0];
                CFG_MESSAGE_LENGTH: msg_len_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input register; it hands its word on when the serializer frees up.
    assign load    = in_valid_reg && ser_free;
    assign s_ready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    smsp_encode u_encode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (load),
        .word           (in_reg),
        .address_digits (addr_digits_reg),
        .message_length (msg_len_reg),
        .job            (job)
    );

    smsp_serial u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .job     (job),
        .free    (ser_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> m_data.run_last)
        else $error("frame end on a word that is not the last of its item");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_valid_reg && !m_valid) |-> s_ready)
        else $error("input blocked while the block is empty");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !load) |=> (in_valid_reg && $stable(in_reg)))
        else $error("pending input word lost");

endmodule
